// File: design/cgf_pkg.sv
package cgf_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int COEF_W     = 17;
    localparam int IDX_W      = 7;
    localparam int TAPCNT_W   = 8;
    localparam int OUT_FIELDS = 4;
    localparam int PROD_W     = SAMPLE_W + COEF_W + 1;
    localparam int ACC_W      = PROD_W + IDX_W;
    localparam int FRAC_SHIFT = 17;
    localparam int Q_W        = ACC_W - FRAC_SHIFT;

    localparam int TAPS_MIN   = 16;
    localparam int TAPS_RESET = 101;

    localparam int APB_DATA_W = 32;
    localparam int REG_ADDR_W = 3;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = 1'b0;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) <<< (FRAC_SHIFT - 1);
    localparam logic signed [Q_W-1:0] Q_MAX =
        {{(Q_W - SAMPLE_W + 1){1'b0}}, {(SAMPLE_W - 1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN =
        {{(Q_W - SAMPLE_W + 1){1'b1}}, {(SAMPLE_W - 1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] OUT_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] OUT_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};

    typedef struct packed {
        logic push;
        logic coef_wr;
        logic issue;
        logic load_res;
        logic load_zero;
    } t_cmd;

    typedef struct packed {
        logic last_issue;
        logic pipe_busy;
    } t_status;

    function automatic logic signed [SAMPLE_W-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] v;
        logic signed [Q_W-1:0]   q;
        logic signed [SAMPLE_W-1:0] r;
        v = acc + ROUND_BIAS;
        q = $signed(v[ACC_W-1:FRAC_SHIFT]);
        if (q > Q_MAX) begin
            r = OUT_MAX;
        end else if (q < Q_MIN) begin
            r = OUT_MIN;
        end else begin
            r = q[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: design/cgf_if.sv
interface cgf_in_if;
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic signed [31:0]   sample_ch0;
    logic signed [31:0]   sample_ch1;
    logic signed [31:0]   sample_ch2;
    logic signed [31:0]   sample_ch3;
    logic [6:0]           coef_index;
    logic [16:0]          coef_value;

    modport source (
        output valid, kind, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
               coef_index, coef_value,
        input  ready
    );
    modport sink (
        input  valid, kind, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
               coef_index, coef_value,
        output ready
    );
endinterface

interface cgf_out_if;
    logic                 valid;
    logic                 ready;
    logic signed [31:0]   filtered_ch0;
    logic signed [31:0]   filtered_ch1;
    logic signed [31:0]   filtered_ch2;
    logic signed [31:0]   filtered_ch3;

    modport source (
        output valid, filtered_ch0, filtered_ch1, filtered_ch2, filtered_ch3,
        input  ready
    );
    modport sink (
        input  valid, filtered_ch0, filtered_ch1, filtered_ch2, filtered_ch3,
        output ready
    );
endinterface

// File: design/causal_gaussian_fir_filter.sv
// Causal FIR smoother for up to four channels of signed Q16.16 samples with
// unsigned Q0.17 tap weights that software loads through coefficient items,
// tap 0 weighting the newest sample. Each sample item gives one result whose
// fields are the per-channel weighted sums, rounded half up to Q16.16 and
// saturated; the first sample item after reset only primes the filter and
// returns zeros, and coefficient items return nothing. One multiplier per
// channel walks min(tap_count, MAX_TAPS, 128) taps, one per clock, for
// every later sample item. The input channel accepts a new item while the
// previous result still waits in the output register. The tap_count
// register sits at byte address 0 of the APB port and only accepts a low
// pwdata byte from 16 to MAX_TAPS; other writes leave it unchanged.
module causal_gaussian_fir_filter #(
    parameter int CHANNELS = 4,
    parameter int MAX_TAPS = 128
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    cgf_in_if.sink                             i_in,
    cgf_out_if.source                          o_out,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cgf_pkg::REG_ADDR_W-1:0]     paddr,
    input  logic [cgf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [cgf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import cgf_pkg::*;

    logic [TAPCNT_W-1:0]        r_tap_count;
    logic [TAPCNT_W-1:0]        w_wr_val;
    logic [CFG_IDX_W-1:0]       w_reg_idx;
    logic                       w_wr_ok;
    t_cmd                       w_cmd;
    t_status                    w_status;
    logic signed [SAMPLE_W-1:0] w_samples [OUT_FIELDS];
    logic signed [SAMPLE_W-1:0] w_res [OUT_FIELDS];

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[REG_ADDR_W-1:2];
    assign w_wr_val  = pwdata[TAPCNT_W-1:0];
    assign w_wr_ok   = (w_wr_val >= TAPCNT_W'(TAPS_MIN)) &&
                       ({{(APB_DATA_W - TAPCNT_W){1'b0}}, w_wr_val} <= APB_DATA_W'(MAX_TAPS));
    assign prdata    = (w_reg_idx == CFG_TAP_COUNT) ?
                       {{(APB_DATA_W - TAPCNT_W){1'b0}}, r_tap_count} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAPCNT_W'(TAPS_RESET);
        end else if (psel && penable && pwrite && pready &&
                     (w_reg_idx == CFG_TAP_COUNT) && w_wr_ok) begin
            r_tap_count <= w_wr_val;
        end
    end

    assign w_samples[0] = i_in.sample_ch0;
    assign w_samples[1] = i_in.sample_ch1;
    assign w_samples[2] = i_in.sample_ch2;
    assign w_samples[3] = i_in.sample_ch3;

    cgf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_kind      (i_in.kind),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    cgf_dp #(
        .CHANNELS (CHANNELS),
        .MAX_TAPS (MAX_TAPS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_tap_count  (r_tap_count),
        .i_samples    (w_samples),
        .i_coef_index (i_in.coef_index),
        .i_coef_value (i_in.coef_value),
        .o_res        (w_res)
    );

    assign o_out.filtered_ch0 = w_res[0];
    assign o_out.filtered_ch1 = w_res[1];
    assign o_out.filtered_ch2 = w_res[2];
    assign o_out.filtered_ch3 = w_res[3];
endmodule

// File: design/cgf_ram.sv
module cgf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/cgf_ctrl.sv
module cgf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_kind,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output cgf_pkg::t_cmd   o_cmd,
    input  cgf_pkg::t_status i_status
);
    import cgf_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SWEEP  = 5'b00010,
        S_DRAIN  = 5'b00100,
        S_RESULT = 5'b01000,
        S_ZERO   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_primed, n_primed;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_out_free;
    t_cmd   w_cmd;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

    always_comb begin
        n_state  = r_state;
        n_primed = r_primed;
        w_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_kind == KIND_COEF) begin
                        w_cmd.coef_wr = 1'b1;
                    end else if (!r_primed) begin
                        n_primed = 1'b1;
                        n_state  = S_ZERO;
                    end else begin
                        w_cmd.push = 1'b1;
                        n_state    = S_SWEEP;
                    end
                end
            end
            S_SWEEP: begin
                w_cmd.issue = 1'b1;
                if (i_status.last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (w_out_free) begin
                    w_cmd.load_res = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_ZERO: begin
                if (w_out_free) begin
                    w_cmd.load_zero = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (w_cmd.load_res || w_cmd.load_zero) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_primed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_primed    <= n_primed;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

// File: design/cgf_dp.sv
module cgf_dp #(
    parameter int CHANNELS = 4,
    parameter int MAX_TAPS = 128
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  cgf_pkg::t_cmd                          i_cmd,
    output cgf_pkg::t_status                       o_status,
    input  logic [cgf_pkg::TAPCNT_W-1:0]           i_tap_count,
    input  logic signed [cgf_pkg::SAMPLE_W-1:0]    i_samples [cgf_pkg::OUT_FIELDS],
    input  logic [cgf_pkg::IDX_W-1:0]              i_coef_index,
    input  logic [cgf_pkg::COEF_W-1:0]             i_coef_value,
    output logic signed [cgf_pkg::SAMPLE_W-1:0]    o_res [cgf_pkg::OUT_FIELDS]
);
    import cgf_pkg::*;

    localparam int WDEPTH  = (MAX_TAPS < (1 << IDX_W)) ? MAX_TAPS : (1 << IDX_W);
    localparam int HADDR_W = $clog2(MAX_TAPS);
    localparam int WADDR_W = $clog2(WDEPTH);
    localparam int CNT_W   = $clog2(WDEPTH + 1);

    logic [HADDR_W-1:0] r_newest;
    logic [HADDR_W-1:0] w_newest_inc;
    logic [HADDR_W-1:0] r_rd_slot;
    logic [CNT_W-1:0]   r_fill;
    logic [CNT_W-1:0]   r_tap;
    logic [CNT_W-1:0]   w_eff;
    logic [WDEPTH-1:0]  r_wvalid;
    logic               r_v1, r_v2;
    logic               r_hv1, r_wv1;
    logic               w_coef_ok;
    logic [COEF_W-1:0]  w_wdata;

    assign w_newest_inc = (r_newest == HADDR_W'(MAX_TAPS - 1)) ? '0 : r_newest + 1'b1;
    assign w_eff = ({1'b0, i_tap_count} >= (TAPCNT_W + 1)'(WDEPTH)) ?
                   CNT_W'(WDEPTH) : i_tap_count[CNT_W-1:0];
    assign w_coef_ok = ({1'b0, i_coef_index} < (IDX_W + 1)'(WDEPTH));

    assign o_status.last_issue = (r_tap == w_eff - CNT_W'(1));
    assign o_status.pipe_busy  = r_v1 || r_v2;

    cgf_ram #(
        .WIDTH (COEF_W),
        .DEPTH (WDEPTH)
    ) u_wram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.coef_wr && w_coef_ok),
        .i_waddr (i_coef_index[WADDR_W-1:0]),
        .i_wdata (i_coef_value),
        .i_raddr (r_tap[WADDR_W-1:0]),
        .o_rdata (w_wdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newest  <= '0;
            r_fill    <= '0;
            r_wvalid  <= '0;
            r_tap     <= '0;
            r_rd_slot <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_hv1     <= 1'b0;
            r_wv1     <= 1'b0;
        end else begin
            r_v2 <= r_v1;
            if (i_cmd.coef_wr && w_coef_ok) begin
                r_wvalid[i_coef_index[WADDR_W-1:0]] <= 1'b1;
            end
            if (i_cmd.push) begin
                r_newest  <= w_newest_inc;
                r_rd_slot <= w_newest_inc;
                r_tap     <= '0;
                if (r_fill != CNT_W'(WDEPTH)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (i_cmd.issue) begin
                r_v1      <= 1'b1;
                r_hv1     <= (r_tap < r_fill);
                r_wv1     <= r_wvalid[r_tap[WADDR_W-1:0]];
                r_tap     <= r_tap + 1'b1;
                r_rd_slot <= (r_rd_slot == '0) ? HADDR_W'(MAX_TAPS - 1) : r_rd_slot - 1'b1;
            end else begin
                r_v1 <= 1'b0;
            end
        end
    end

    for (genvar c = 0; c < OUT_FIELDS; c++) begin : g_lane
        if (c < CHANNELS) begin : g_used
            logic [SAMPLE_W-1:0]        w_hdata;
            logic signed [PROD_W-1:0]   r_prod;
            logic signed [ACC_W-1:0]    r_acc;
            logic signed [SAMPLE_W-1:0] r_res;

            cgf_ram #(
                .WIDTH (SAMPLE_W),
                .DEPTH (MAX_TAPS)
            ) u_hram (
                .i_clk   (i_clk),
                .i_we    (i_cmd.push),
                .i_waddr (w_newest_inc),
                .i_wdata (i_samples[c]),
                .i_raddr (r_rd_slot),
                .o_rdata (w_hdata)
            );

            always_ff @(posedge i_clk) begin
                if (r_hv1 && r_wv1) begin
                    r_prod <= $signed(w_hdata) * $signed({1'b0, w_wdata});
                end else begin
                    r_prod <= '0;
                end
                if (i_cmd.push) begin
                    r_acc <= '0;
                end else if (r_v2) begin
                    r_acc <= r_acc + ACC_W'(r_prod);
                end
                if (i_cmd.load_res) begin
                    r_res <= round_sat(r_acc);
                end else if (i_cmd.load_zero) begin
                    r_res <= '0;
                end
            end

            assign o_res[c] = r_res;
        end else begin : g_unused
            assign o_res[c] = '0;
        end
    end
endmodule

// File: verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cgf_pkg::*;

    localparam int CHAN            = 4;
    localparam int DEPTH           = 128;
    localparam int IDLE_PCT        = 23;
    localparam int HOLD_CYCLES     = 800;
    localparam int SETTLE_CYCLES   = 2 * DEPTH + 16;
    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int SPARE_REG       = 1;

    localparam logic [REG_ADDR_W-1:0] TAPS_ADDR  = REG_ADDR_W'(4 * CFG_TAP_COUNT);
    localparam logic [REG_ADDR_W-1:0] SPARE_ADDR = REG_ADDR_W'(4 * SPARE_REG);

    localparam longint HALF_LSB   = longint'(1) <<< (FRAC_SHIFT - 1);
    localparam longint OUT_TOP    = 64'sd2147483647;
    localparam longint OUT_BOTTOM = -64'sd2147483648;

    typedef logic [CHAN-1:0][SAMPLE_W-1:0] t_quad;

    typedef struct packed {
        logic              kind;
        t_quad             smp;
        logic [IDX_W-1:0]  cidx;
        logic [COEF_W-1:0] cval;
    } t_fir_item;

    class t_fir_tracker;
        logic signed [SAMPLE_W-1:0] hist [CHAN][DEPTH];
        logic [COEF_W-1:0]          wt [DEPTH];
        logic [IDX_W-1:0]           slot;
        bit                         primed;
        logic [TAPCNT_W-1:0]        taps;
        t_quad                      awaited [$];
        int                         faults;

        function new();
            foreach (wt[j]) wt[j] = '0;
            foreach (hist[c, j]) hist[c][j] = '0;
            slot   = '0;
            primed = 1'b0;
            taps   = TAPCNT_W'(TAPS_RESET);
            faults = 0;
        endfunction

        function void report(string what, logic [31:0] want, logic [31:0] got);
            if (faults < 10) begin
                $display("%s: expected %h, got %h", what, want, got);
            end
            faults++;
        endfunction

        function void take_config(int idx, logic [31:0] data);
            if (idx == CFG_TAP_COUNT && data[7:0] >= TAPS_MIN && data[7:0] <= DEPTH) begin
                taps = data[7:0];
            end
        endfunction

        function void take_item(t_fir_item it);
            t_quad            want;
            longint           acc;
            longint           q;
            logic [IDX_W-1:0] pos;
            if (it.kind == KIND_COEF) begin
                wt[it.cidx] = it.cval;
                return;
            end
            want = '0;
            if (!primed) begin
                primed = 1'b1;
                awaited = {awaited, want};
                return;
            end
            slot = slot + 1'b1;
            for (int c = 0; c < CHAN; c++) begin
                hist[c][slot] = it.smp[c];
            end
            for (int c = 0; c < CHAN; c++) begin
                acc = 0;
                for (int j = 0; j < taps; j++) begin
                    pos = slot - IDX_W'(j);
                    acc += longint'(hist[c][pos]) * longint'(wt[j]);
                end
                q = (acc + HALF_LSB) >>> FRAC_SHIFT;
                if (q > OUT_TOP) begin
                    q = OUT_TOP;
                end else if (q < OUT_BOTTOM) begin
                    q = OUT_BOTTOM;
                end
                want[c] = q[31:0];
            end
            awaited = {awaited, want};
        endfunction

        function void match_result(t_quad got);
            t_quad want;
            if (awaited.size() == 0) begin
                report("unexpected result, filtered_ch0", '0, got[0]);
                return;
            end
            want = awaited[0];
            awaited.delete(0);
            for (int c = 0; c < CHAN; c++) begin
                if (got[c] !== want[c]) begin
                    report($sformatf("filtered_ch%0d", c), want[c], got[c]);
                end
            end
        endfunction

        function void match_reg(logic [31:0] got);
            if (got !== 32'(taps)) begin
                report("tap_count readback", 32'(taps), got);
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [REG_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    cgf_in_if  in_if ();
    cgf_out_if out_if ();

    t_fir_tracker fir = new();

    bit calm       = 1'b0;
    bit stall_req  = 1'b0;
    int stall_left = 0;
    int cycles     = 0;

    causal_gaussian_fir_filter #(
        .CHANNELS (CHAN),
        .MAX_TAPS (DEPTH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                fir.match_result({out_if.filtered_ch3, out_if.filtered_ch2,
                                  out_if.filtered_ch1, out_if.filtered_ch0});
            end
            if (in_if.valid && in_if.ready) begin
                fir.take_item({in_if.kind,
                               {in_if.sample_ch3, in_if.sample_ch2,
                                in_if.sample_ch1, in_if.sample_ch0},
                               in_if.coef_index, in_if.coef_value});
            end
        end
    end

    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if (stall_req) begin
                stall_req  = 1'b0;
                stall_left = HOLD_CYCLES;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    function automatic t_fir_item coef_item(int idx, int val);
        t_fir_item it;
        it.kind = KIND_COEF;
        it.cidx = IDX_W'(idx);
        it.cval = COEF_W'(val);
        for (int c = 0; c < CHAN; c++) begin
            it.smp[c] = $urandom();
        end
        return it;
    endfunction

    function automatic t_fir_item sample_item(logic [31:0] a, logic [31:0] b,
                                              logic [31:0] c, logic [31:0] d);
        t_fir_item it;
        it.kind = KIND_SAMPLE;
        it.smp  = {d, c, b, a};
        it.cidx = IDX_W'($urandom());
        it.cval = COEF_W'($urandom());
        return it;
    endfunction

    function automatic logic [31:0] pick_sample(int spread);
        int r;
        r = $urandom_range(99);
        if (r < 10) begin
            case ($urandom_range(4))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'h0000_0000;
                3:       return 32'hFFFF_FFFF;
                default: return 32'h0000_0001;
            endcase
        end else if (r < spread) begin
            return $urandom();
        end
        return 32'($urandom_range(0, 2097151)) - 32'd1048576;
    endfunction

    function automatic int pick_weight(int top);
        case ($urandom_range(9))
            0:       return (1 << COEF_W) - 1;
            1:       return 0;
            default: return $urandom_range(0, top);
        endcase
    endfunction

    task automatic send_item(t_fir_item it);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.kind       <= it.kind;
        in_if.sample_ch0 <= it.smp[0];
        in_if.sample_ch1 <= it.smp[1];
        in_if.sample_ch2 <= it.smp[2];
        in_if.sample_ch3 <= it.smp[3];
        in_if.coef_index <= it.cidx;
        in_if.coef_value <= it.cval;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic apb_write(logic [REG_ADDR_W-1:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        fir.take_config(int'(addr >> 2), data);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_taps_reg();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= TAPS_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        fir.match_reg(prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (fir.awaited.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int         taps_val;
        int         wmax;
        int         spread;
        bit         press;
        logic [7:0] junk;
        in_if.valid      <= 1'b0;
        in_if.kind       <= KIND_SAMPLE;
        in_if.sample_ch0 <= '0;
        in_if.sample_ch1 <= '0;
        in_if.sample_ch2 <= '0;
        in_if.sample_ch3 <= '0;
        in_if.coef_index <= '0;
        in_if.coef_value <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        i_rst_n <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_taps_reg();

        // The first sample only primes the filter, so its result is all zero.
        send_item(sample_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1));
        send_item(coef_item(0, 131071));
        send_item(coef_item(1, 131071));
        send_item(sample_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF));
        send_item(sample_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0));
        send_item(sample_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0));
        send_item(sample_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0));
        // A single weight of one LSB exposes the half-up rounding.
        send_item(coef_item(0, 1));
        send_item(coef_item(1, 0));
        send_item(sample_item(32'h0001_0000, 32'hFFFF_0000, 32'h0000_FFFF, 32'hFFFE_FFFF));
        send_item(coef_item(127, 131071));
        send_item(coef_item(100, 77777));
        send_item(coef_item(64, 65536));
        send_item(sample_item(32'h0, 32'h0, 32'h0, 32'h0));
        send_item(sample_item(32'hFFFF_FFFF, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF));
        send_item(sample_item(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'hF0F0_F0F0));

        for (int p = 0; p < PHASES; p++) begin
            press  = 1'b0;
            calm   = 1'b0;
            case (p)
                0: begin taps_val = DEPTH;    wmax = 2047;   spread = 50; end
                1: begin taps_val = TAPS_MIN; wmax = 131071; spread = 60; press = 1'b1; end
                2: begin
                    taps_val = $urandom_range(TAPS_MIN + 1, DEPTH - 1);
                    wmax = 16383; spread = 40;
                end
                3: begin taps_val = 100;      wmax = 131071; spread = 20; end
                4: begin taps_val = TAPS_MIN; wmax = 511;    spread = 90; end
                5: begin
                    taps_val = $urandom_range(TAPS_MIN + 1, DEPTH - 1);
                    wmax = 131071; spread = 50;
                end
                default: begin taps_val = DEPTH; wmax = 4095; spread = 70; end
            endcase
            case (p % 4)
                0:       junk = 8'd0;
                1:       junk = 8'd15;
                2:       junk = 8'd129;
                default: junk = 8'd255;
            endcase
            settle();
            apb_write(SPARE_ADDR, $urandom());
            apb_write(TAPS_ADDR, {24'($urandom_range(0, 16777215)), junk});
            check_taps_reg();
            apb_write(TAPS_ADDR, {24'($urandom_range(0, 16777215)), 8'(taps_val)});
            check_taps_reg();
            calm = (p == 1) || (p == 2);
            if (press) begin
                stall_req = 1'b1;
            end
            repeat (ITEMS_PER_PHASE) begin
                if ($urandom_range(99) < 20) begin
                    send_item(coef_item($urandom_range(0, DEPTH - 1), pick_weight(wmax)));
                end else begin
                    send_item(sample_item(pick_sample(spread), pick_sample(spread),
                                          pick_sample(spread), pick_sample(spread)));
                end
            end
        end
        calm = 1'b0;
        settle();

        if (fir.faults == 0 && fir.awaited.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/cgf_pkg.sv
design/cgf_if.sv
design/cgf_ram.sv
design/cgf_ctrl.sv
design/cgf_dp.sv
design/causal_gaussian_fir_filter.sv
verif/tb.sv
